// File: rtl/iprl_pkg.sv
// ----------------------------------------------------------------------------
// iprl_pkg
// Shared sizes, table entry layout and address compare for the range lookup.
// ----------------------------------------------------------------------------
package iprl_pkg;

  localparam int MAX_RANGES  = 1024;
  localparam int REGION_BITS = 32;

  // stored region width never exceeds the 32-bit region field
  localparam int REG_W   = (REGION_BITS < 32) ? REGION_BITS : 32;
  localparam int IDX_W   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W   = $clog2(MAX_RANGES + 1);
  localparam int ENTRY_W = 256 + REG_W;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_BUILD  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_REVERSED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_OVERLAP  = 3'd3;
  localparam logic [2:0] ST_NOTBUILT = 3'd4;

  typedef struct packed {
    logic [REG_W-1:0] region;
    logic [63:0]      end_lo;
    logic [63:0]      end_hi;
    logic [63:0]      start_lo;
    logic [63:0]      start_hi;
  } entry_t;

  // unsigned 128-bit a < b, hi word first
  function automatic logic less128(input logic [63:0] ah, input logic [63:0] al,
                                   input logic [63:0] bh, input logic [63:0] bl);
    less128 = (ah != bh) ? (ah < bh) : (al < bl);
  endfunction

endpackage

// File: rtl/iprl_ram.sv
// ----------------------------------------------------------------------------
// iprl_ram
// Generic single-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module iprl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/ip_range_region_lookup.sv
// ----------------------------------------------------------------------------
// ip_range_region_lookup
// Range table with insert, in-place sort and overlap check, and binary search.
//
//   channel  dir  tdata fields (lsb up)                               tuser
//   s_*      in   first_hi, first_lo, last_hi, last_lo, region (288)  command
//   m_*      out  status, found, match_region, zero pad (40)          -
//
// insert and unknown commands go from S_IDLE straight to S_DONE, which registers the result.
// lookup makes one table read per search step.
// build is an insertion sort plus a linear check, O(entries^2) memory reads.
// rst clears entry count and ready flag; the table memory is not cleared.
// one command at a time; the next beat is taken while a result waits on m_*.
// ----------------------------------------------------------------------------
module ip_range_region_lookup
  import iprl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,   // first_hi, first_lo, last_hi, last_lo, region
  input  logic [1:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata    // status, found, match_region, zero pad
);

  typedef enum logic [3:0] {
    S_IDLE, S_DONE,
    S_B_NEXT, S_B_KEY, S_B_CMP, S_B_PUT,
    S_C_START, S_C_FIRST, S_C_CMP,
    S_L_STEP, S_L_CMP, S_L_END
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] entry_count;
  logic             table_ready;
  entry_t           key;
  logic [CNT_W-1:0] idx_a;   // sort outer index, lookup lo, check index
  logic [CNT_W-1:0] idx_b;   // sort insert position, lookup hi
  logic [CNT_W-1:0] mid;
  logic [127:0]     prev_end;
  logic [2:0]       res_status;
  logic             res_found;
  logic [REG_W-1:0] res_region;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  // input beat decode
  logic   s_accept;
  logic   in_rev;
  logic   in_full;
  entry_t in_entry;
  logic [CNT_W-1:0] mid_calc;
  logic   key_lt_prev;
  logic   check_ok;
  logic   addr_lt_start;

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;

  assign in_entry.start_hi = s_tdata[63:0];
  assign in_entry.start_lo = s_tdata[127:64];
  assign in_entry.end_hi   = s_tdata[191:128];
  assign in_entry.end_lo   = s_tdata[255:192];
  assign in_entry.region   = s_tdata[256 +: REG_W];

  assign in_rev  = less128(in_entry.end_hi, in_entry.end_lo,
                           in_entry.start_hi, in_entry.start_lo);
  assign in_full = (entry_count >= CNT_W'(MAX_RANGES));

  assign mid_calc      = idx_a + ((idx_b - idx_a) >> 1);
  assign key_lt_prev   = less128(key.start_hi, key.start_lo,
                                 rd_data.start_hi, rd_data.start_lo);
  assign check_ok      = less128(prev_end[127:64], prev_end[63:0],
                                 rd_data.start_hi, rd_data.start_lo);
  assign addr_lt_start = key_lt_prev;

  // table memory
  iprl_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = key;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        if (s_accept && s_tuser == CMD_INSERT && !in_rev && !in_full) begin
          wr_en   = 1'b1;
          wr_addr = entry_count[IDX_W-1:0];
          wr_data = in_entry;
        end
      end
      S_B_NEXT: begin
        rd_en   = (idx_a < entry_count);
        rd_addr = idx_a[IDX_W-1:0];
      end
      S_B_KEY: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(idx_a - CNT_W'(1));
      end
      S_B_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx_b[IDX_W-1:0];
        if (key_lt_prev) begin
          wr_data = rd_data;
          rd_en   = (idx_b != CNT_W'(1));
          rd_addr = IDX_W'(idx_b - CNT_W'(2));
        end
      end
      S_B_PUT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      S_C_START: begin
        rd_en   = (entry_count >= CNT_W'(2));
        rd_addr = '0;
      end
      S_C_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(1);
      end
      S_C_CMP: begin
        rd_en   = check_ok && (idx_a != entry_count - CNT_W'(1));
        rd_addr = IDX_W'(idx_a + CNT_W'(1));
      end
      S_L_STEP: begin
        if (idx_a < idx_b) begin
          rd_en   = 1'b1;
          rd_addr = mid_calc[IDX_W-1:0];
        end else begin
          rd_en   = (idx_a != '0);
          rd_addr = IDX_W'(idx_a - CNT_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer, table state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      table_ready <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // output beat taken; a result ready in S_DONE reloads it instead
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            res_status <= ST_OK;
            res_found  <= 1'b0;
            res_region <= '0;
            key        <= in_entry;
            state      <= S_DONE;
            case (s_tuser)
              CMD_INSERT: begin
                if (in_rev) begin
                  res_status <= ST_REVERSED;
                end else if (in_full) begin
                  res_status <= ST_FULL;
                end else begin
                  entry_count <= entry_count + CNT_W'(1);
                  table_ready <= 1'b0;
                end
              end
              CMD_BUILD: begin
                idx_a <= CNT_W'(1);
                state <= S_B_NEXT;
              end
              CMD_LOOKUP: begin
                if (!table_ready) begin
                  res_status <= ST_NOTBUILT;
                end else begin
                  idx_a <= '0;
                  idx_b <= entry_count;
                  state <= S_L_STEP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, 32'(res_region), res_found, res_status};
            state    <= S_IDLE;
          end
        end
        // insertion sort: hold key, shift larger entries up
        S_B_NEXT: begin
          state <= (idx_a < entry_count) ? S_B_KEY : S_C_START;
        end
        S_B_KEY: begin
          key   <= rd_data;
          idx_b <= idx_a;
          state <= S_B_CMP;
        end
        S_B_CMP: begin
          if (key_lt_prev) begin
            idx_b <= idx_b - CNT_W'(1);
            state <= (idx_b == CNT_W'(1)) ? S_B_PUT : S_B_CMP;
          end else begin
            idx_a <= idx_a + CNT_W'(1);
            state <= S_B_NEXT;
          end
        end
        S_B_PUT: begin
          idx_a <= idx_a + CNT_W'(1);
          state <= S_B_NEXT;
        end
        // overlap check over neighbors
        S_C_START: begin
          if (entry_count < CNT_W'(2)) begin
            table_ready <= 1'b1;
            state       <= S_DONE;
          end else begin
            state <= S_C_FIRST;
          end
        end
        S_C_FIRST: begin
          prev_end <= {rd_data.end_hi, rd_data.end_lo};
          idx_a    <= CNT_W'(1);
          state    <= S_C_CMP;
        end
        S_C_CMP: begin
          if (!check_ok) begin
            res_status  <= ST_OVERLAP;
            table_ready <= 1'b0;
            state       <= S_DONE;
          end else if (idx_a == entry_count - CNT_W'(1)) begin
            table_ready <= 1'b1;
            state       <= S_DONE;
          end else begin
            prev_end <= {rd_data.end_hi, rd_data.end_lo};
            idx_a    <= idx_a + CNT_W'(1);
          end
        end
        // binary search for first start above the address
        S_L_STEP: begin
          if (idx_a < idx_b) begin
            mid   <= mid_calc;
            state <= S_L_CMP;
          end else begin
            state <= (idx_a != '0) ? S_L_END : S_DONE;
          end
        end
        S_L_CMP: begin
          if (addr_lt_start) begin
            idx_b <= mid;
          end else begin
            idx_a <= mid + CNT_W'(1);
          end
          state <= S_L_STEP;
        end
        S_L_END: begin
          if (!less128(rd_data.end_hi, rd_data.end_lo, key.start_hi, key.start_lo)) begin
            res_found  <= 1'b1;
            res_region <= rd_data.region;
          end
          state <= S_DONE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // table never grows past its depth
  assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_RANGES))
    else $error("entry count above table depth");

  // no table writes while searching
  assert property (@(posedge clk) disable iff (rst)
    (state == S_L_STEP || state == S_L_CMP || state == S_L_END) |-> !wr_en)
    else $error("table write during lookup");

  // search window stays inside the table
  assert property (@(posedge clk) disable iff (rst)
    (state == S_L_STEP) |-> (idx_b <= entry_count && idx_a <= idx_b))
    else $error("search bounds out of range");

  // a stored insert drops the ready flag
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && wr_en) |=> !table_ready)
    else $error("ready flag kept after insert");

endmodule
